>>> design/bnd_pkg.sv
// Shared types, constants and arithmetic helpers for the Bayer demosaic block.
`timescale 1ns / 1ps

package bnd_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int POS_W      = 2;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 12'd640;

  // x / 3 == (x * 683) >> 11 for every x below 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PW    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd1;

  localparam logic [POS_W-1:0] POS_UL = 2'd0;
  localparam logic [POS_W-1:0] POS_UR = 2'd1;
  localparam logic [POS_W-1:0] POS_LL = 2'd2;
  localparam logic [POS_W-1:0] POS_LR = 2'd3;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_STORE,
    KIND_HOLD,
    KIND_QUAD
  } kind_t;

  typedef struct packed {
    kind_t kind;
  } pix_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] g_mean;
    logic [PIX_W-1:0] g_ur;
    logic [PIX_W-1:0] g_ll;
  } quad_t;

  function automatic logic [SUM_W-1:0] pix_sum(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
    pix_sum = SUM_W'(b) + SUM_W'(g) + SUM_W'(r);
  endfunction

  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [DIV3_PW-1:0] p;
    p = DIV3_PW'(x) * DIV3_PW'(DIV3_MUL);
    div3 = p[DIV3_SHIFT +: PIX_W];
  endfunction

endpackage

>>> design/bnd_line_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bnd_line_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/bnd_raster.sv
// Column and row tracking: classifies each pixel and gives its line store address.
`timescale 1ns / 1ps

module bnd_raster #(
  parameter int MAX_WIDTH = bnd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         frame_start,
  input  logic [bnd_pkg::ROW_W-1:0]    row_width,
  output bnd_pkg::pix_ctl_t            ctl,
  output logic [$clog2(MAX_WIDTH)-1:0] col
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (LW > bnd_pkg::ROW_W) ? LW : bnd_pkg::ROW_W;

  logic [AW-1:0] col_r, col_nxt, col_eff;
  logic          odd_r, odd_nxt, odd_eff;
  logic [CW-1:0] rw_ext, limit_c;
  logic [LW-1:0] limit, width, col_ext, col_inc;
  logic          used;

  always_comb begin
    rw_ext = CW'(row_width);
    priority if (rw_ext < CW'(2)) begin
      limit_c = CW'(2);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      limit_c = CW'(MAX_WIDTH);
    end else begin
      limit_c = rw_ext;
    end
    limit = limit_c[LW-1:0];
    width = {limit[LW-1:1], 1'b0};
  end

  assign col_eff = frame_start ? '0 : col_r;
  assign odd_eff = frame_start ? 1'b0 : odd_r;
  assign col_ext = LW'(col_eff);
  assign col_inc = col_ext + LW'(1);
  assign used    = col_ext < width;

  always_comb begin
    priority if (!used) begin
      ctl.kind = bnd_pkg::KIND_SKIP;
    end else if (!odd_eff) begin
      ctl.kind = bnd_pkg::KIND_STORE;
    end else if (!col_eff[0]) begin
      ctl.kind = bnd_pkg::KIND_HOLD;
    end else begin
      ctl.kind = bnd_pkg::KIND_QUAD;
    end
  end

  always_comb begin
    if (col_inc >= limit) begin
      col_nxt = '0;
      odd_nxt = ~odd_eff;
    end else begin
      col_nxt = col_inc[AW-1:0];
      odd_nxt = odd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  assign col = col_eff;

endmodule

>>> design/bnd_quad.sv
// Quad stage: holds the left column of a quad and works out the colors at the right one.
`timescale 1ns / 1ps

module bnd_quad (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  bnd_pkg::pix_ctl_t         ctl,
  input  logic [bnd_pkg::SUM_W-1:0] sum,
  input  logic [bnd_pkg::SUM_W-1:0] rd_data,
  input  logic                      pattern,
  output logic                      ready,
  output logic                      q_valid,
  input  logic                      q_ready,
  output bnd_pkg::quad_t            quad
);

  logic                      a_valid_r, a_quad_r;
  logic [bnd_pkg::SUM_W-1:0] a_sum_r, ul_r, left_r;
  logic                      a_adv, take;
  logic [bnd_pkg::SUM_W:0]   g_pair;
  logic [bnd_pkg::PIX_W-1:0] ul_d3, lr_d3;

  assign a_adv   = a_valid_r && (!a_quad_r || q_ready);
  assign ready   = !a_valid_r || a_adv;
  assign q_valid = a_valid_r && a_quad_r;
  assign take    = in_fire &&
                   (ctl.kind == bnd_pkg::KIND_HOLD || ctl.kind == bnd_pkg::KIND_QUAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_quad_r  <= 1'b0;
      ul_r      <= '0;
      left_r    <= '0;
    end else begin
      if (take) begin
        a_valid_r <= 1'b1;
        a_quad_r  <= (ctl.kind == bnd_pkg::KIND_QUAD);
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      // latch the left column of the quad
      if (a_adv && !a_quad_r) begin
        ul_r   <= rd_data;
        left_r <= a_sum_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_sum_r <= sum;
    end
  end

  // UL = held upper sum, UR = line store read, LL = held left sum, LR = this pixel
  always_comb begin
    g_pair      = (bnd_pkg::SUM_W + 1)'(rd_data) + (bnd_pkg::SUM_W + 1)'(left_r);
    ul_d3       = bnd_pkg::div3(ul_r);
    lr_d3       = bnd_pkg::div3(a_sum_r);
    quad.red    = pattern ? lr_d3 : ul_d3;
    quad.blue   = pattern ? ul_d3 : lr_d3;
    quad.g_mean = bnd_pkg::div3(g_pair[bnd_pkg::SUM_W:1]);
    quad.g_ur   = bnd_pkg::div3(rd_data);
    quad.g_ll   = bnd_pkg::div3(left_r);
  end

endmodule

>>> design/bnd_emit.sv
// Result sequencer: plays out the four pixels of a quad, one per accepted item.
`timescale 1ns / 1ps

module bnd_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  bnd_pkg::quad_t            quad,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bnd_pkg::PIX_W-1:0] out_red,
  output logic [bnd_pkg::PIX_W-1:0] out_green,
  output logic [bnd_pkg::PIX_W-1:0] out_blue,
  output logic [bnd_pkg::POS_W-1:0] out_pos,
  output logic                      out_last
);

  logic                      busy_r;
  logic [bnd_pkg::POS_W-1:0] pos_r;
  bnd_pkg::quad_t            quad_r;
  logic                      out_fire, done;

  assign out_fire = busy_r && out_ready;
  assign done     = out_fire && (pos_r == bnd_pkg::POS_LR);
  assign q_ready  = !busy_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= bnd_pkg::POS_UL;
    end else if (q_valid && q_ready) begin
      busy_r <= 1'b1;
      pos_r  <= bnd_pkg::POS_UL;
    end else if (done) begin
      busy_r <= 1'b0;
      pos_r  <= bnd_pkg::POS_UL;
    end else if (out_fire) begin
      pos_r  <= pos_r + bnd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      quad_r <= quad;
    end
  end

  always_comb begin
    unique case (pos_r)
      bnd_pkg::POS_UR: out_green = quad_r.g_ur;
      bnd_pkg::POS_LL: out_green = quad_r.g_ll;
      default:         out_green = quad_r.g_mean;
    endcase
  end

  assign out_valid = busy_r;
  assign out_red   = quad_r.red;
  assign out_blue  = quad_r.blue;
  assign out_pos   = pos_r;
  assign out_last  = (pos_r == bnd_pkg::POS_LR);

endmodule

>>> design/bayer_nearest_demosaic.sv
// Top level of the nearest-neighbor Bayer demosaic block.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | in_blue_in, in_green_in, in_red_in, in_frame_start
//  out     | out_valid/ out_ready | out_red_out, out_green_out, out_blue_out,
//          |                      | out_quad_position, out_last
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (0 pattern, 1 row_width)
//
// An item is taken every cycle on even rows while the quad stage holds no quad. On odd
// rows each two items complete a quad that yields four results; the result sequencer
// plays one result a cycle while out_ready is high, so it sets the odd-row rate.
// A quad's first result passes the quad stage register, then the sequencer registers.
// Reset (synchronous, active low) clears the counters and handshake state; the line
// store needs no clearing pass. A stalled output holds the quad stage, which in
// turn holds in_ready low; cfg_ready is always high.
`timescale 1ns / 1ps

module bayer_nearest_demosaic #(
  parameter int MAX_WIDTH = bnd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bnd_pkg::PIX_W-1:0]      in_blue_in,
  input  logic [bnd_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bnd_pkg::PIX_W-1:0]      in_red_in,
  input  logic                           in_frame_start,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bnd_pkg::PIX_W-1:0]      out_red_out,
  output logic [bnd_pkg::PIX_W-1:0]      out_green_out,
  output logic [bnd_pkg::PIX_W-1:0]      out_blue_out,
  output logic [bnd_pkg::POS_W-1:0]      out_quad_position,
  output logic                           out_last,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bnd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                      pattern_r;
  logic [bnd_pkg::ROW_W-1:0] row_width_r;

  logic                      in_fire;
  bnd_pkg::pix_ctl_t         ctl;
  logic [AW-1:0]             col;
  logic [bnd_pkg::SUM_W-1:0] sum, rd_data;
  logic                      ram_we, ram_re;
  logic                      q_valid, q_ready;
  bnd_pkg::quad_t            quad;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= 1'b0;
      row_width_r <= bnd_pkg::ROW_WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bnd_pkg::REG_PATTERN:   pattern_r   <= cfg_data[0];
        bnd_pkg::REG_ROW_WIDTH: row_width_r <= cfg_data[bnd_pkg::ROW_W-1:0];
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;
  assign sum     = bnd_pkg::pix_sum(in_blue_in, in_green_in, in_red_in);

  // Track column and row parity; classify the pixel before it is taken.
  bnd_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .frame_start (in_frame_start),
    .row_width   (row_width_r),
    .ctl         (ctl),
    .col         (col)
  );

  // Even rows store their sums; odd rows read the upper sum at the same column.
  assign ram_we = in_fire && (ctl.kind == bnd_pkg::KIND_STORE);
  assign ram_re = in_fire &&
                  (ctl.kind == bnd_pkg::KIND_HOLD || ctl.kind == bnd_pkg::KIND_QUAD);

  bnd_line_ram #(
    .WIDTH (bnd_pkg::SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col),
    .wdata (sum),
    .re    (ram_re),
    .raddr (col),
    .rdata (rd_data)
  );

  // Hold the left column, then compute the quad at the right column.
  bnd_quad u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .ctl     (ctl),
    .sum     (sum),
    .rd_data (rd_data),
    .pattern (pattern_r),
    .ready   (in_ready),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .quad    (quad)
  );

  // Drain each quad as UL, UR, LL, LR.
  bnd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .quad      (quad),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red_out),
    .out_green (out_green_out),
    .out_blue  (out_blue_out),
    .out_pos   (out_quad_position),
    .out_last  (out_last)
  );

endmodule

>>> sim/bayer_nearest_demosaic_tb.sv
// Self-checking testbench for the nearest-neighbor Bayer demosaic block.
`timescale 1ns / 1ps

module bayer_nearest_demosaic_tb;

  localparam int MAX_W         = bnd_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 8;          // leave margin for the block to settle
  localparam int HOLD_CYCLES   = 300;        // long receiver hold-off for the fill-up test
  localparam int CYCLE_LIMIT   = 5000000;
  localparam int REPORT_CAP    = 100;
  localparam int PARTIAL_LEN   = 40;         // pixels sent into a row too long to finish

  // One demosaiced pixel as the block presents it.
  typedef struct packed {
    logic [bnd_pkg::PIX_W-1:0] red;
    logic [bnd_pkg::PIX_W-1:0] green;
    logic [bnd_pkg::PIX_W-1:0] blue;
    logic [bnd_pkg::POS_W-1:0] pos;
    logic                      last;
  } rgb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [bnd_pkg::PIX_W-1:0]      in_blue_in = '0;
  logic [bnd_pkg::PIX_W-1:0]      in_green_in = '0;
  logic [bnd_pkg::PIX_W-1:0]      in_red_in = '0;
  logic                           in_frame_start = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bnd_pkg::PIX_W-1:0]      out_red_out;
  logic [bnd_pkg::PIX_W-1:0]      out_green_out;
  logic [bnd_pkg::PIX_W-1:0]      out_blue_out;
  logic [bnd_pkg::POS_W-1:0]      out_quad_position;
  logic                           out_last;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bnd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bnd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bayer_nearest_demosaic DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_blue_in        (in_blue_in),
    .in_green_in       (in_green_in),
    .in_red_in         (in_red_in),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_quad_position (out_quad_position),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the block's line store, counters and registers.
  // ---------------------------------------------------------------------------
  logic [bnd_pkg::SUM_W-1:0] line_sums [MAX_W];
  int unsigned               col_count = 0;
  bit                        on_odd_row = 1'b0;
  int unsigned               left_sum = 0;
  bit                        cfg_pattern = 1'b0;
  logic [bnd_pkg::ROW_W-1:0] cfg_row_width = bnd_pkg::ROW_WIDTH_RESET;

  rgb_result_t pending_pixels[$];   // demosaiced pixels still owed by the block

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  bit          hold_request = 1'b0;

  // Pixels per row as the block counts them: row_width clamped to [2, MAX_W].
  function automatic int unsigned row_limit();
    if (cfg_row_width < 2) return 2;
    if (cfg_row_width > MAX_W) return MAX_W;
    return int'(cfg_row_width);
  endfunction

  function automatic logic [bnd_pkg::PIX_W-1:0] rand_byte();
    rand_byte = bnd_pkg::PIX_W'($urandom_range(255));
  endfunction

  function automatic void queue_result(input int unsigned red, input int unsigned green,
                                       input int unsigned blue,
                                       input logic [bnd_pkg::POS_W-1:0] pos);
    rgb_result_t px;
    px.red   = red[bnd_pkg::PIX_W-1:0];
    px.green = green[bnd_pkg::PIX_W-1:0];
    px.blue  = blue[bnd_pkg::PIX_W-1:0];
    px.pos   = pos;
    px.last  = (pos == bnd_pkg::POS_LR);
    pending_pixels.push_back(px);
  endfunction

  // Advance the shadow state by one accepted pixel and queue the quad it completes.
  function automatic void predict_pixel(input logic [bnd_pkg::PIX_W-1:0] b,
                                        input logic [bnd_pkg::PIX_W-1:0] g,
                                        input logic [bnd_pkg::PIX_W-1:0] r, input logic fs);
    int unsigned lim, eff, chan_sum, ul, ur, ll, lr, red_v, blue_v, g_mean;
    chan_sum = int'(b) + int'(g) + int'(r);
    lim = row_limit();
    eff = lim & ~32'd1;       // odd last column never joins a quad
    if (fs) begin
      col_count = 0;
      on_odd_row = 1'b0;
    end
    if (col_count < eff) begin
      if (!on_odd_row) begin
        line_sums[col_count] = chan_sum[bnd_pkg::SUM_W-1:0];
      end else if (col_count % 2 == 0) begin
        left_sum = chan_sum;
      end else begin
        ul = line_sums[col_count-1];
        ur = line_sums[col_count];
        ll = left_sum;
        lr = chan_sum;
        // RGGB puts red upper-left; BGGR swaps red and blue sites
        red_v  = cfg_pattern ? lr / 3 : ul / 3;
        blue_v = cfg_pattern ? ul / 3 : lr / 3;
        g_mean = (ur + ll) / 6;
        queue_result(red_v, g_mean, blue_v, bnd_pkg::POS_UL);
        queue_result(red_v, ur / 3, blue_v, bnd_pkg::POS_UR);
        queue_result(red_v, ll / 3, blue_v, bnd_pkg::POS_LL);
        queue_result(red_v, g_mean, blue_v, bnd_pkg::POS_LR);
      end
    end
    // A row ends once the count reaches its clamped length, also after a narrowing write.
    col_count++;
    if (col_count >= lim) begin
      col_count = 0;
      on_odd_row = !on_odd_row;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the result checker.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_CAP)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  rgb_result_t want_px;

  // Compare every accepted result with the oldest pixel still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending, position", out_quad_position, 0);
      end else begin
        want_px = pending_pixels.pop_front();
        if (out_red_out !== want_px.red)
          report_mismatch("red", out_red_out, want_px.red);
        if (out_green_out !== want_px.green)
          report_mismatch("green", out_green_out, want_px.green);
        if (out_blue_out !== want_px.blue)
          report_mismatch("blue", out_blue_out, want_px.blue);
        if (out_quad_position !== want_px.pos)
          report_mismatch("quad position", out_quad_position, want_px.pos);
        if (out_last !== want_px.last)
          report_mismatch("last", out_last, want_px.last);
      end
    end
  end

  // Bound the run: a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off when a test asks for it.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned burst, held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // Hold ready low while the sender keeps pushing, so the block backs up.
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
        burst = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offer one pixel, hold it until taken, then advance the predictor.
  task automatic send_pixel(input logic [bnd_pkg::PIX_W-1:0] b,
                            input logic [bnd_pkg::PIX_W-1:0] g,
                            input logic [bnd_pkg::PIX_W-1:0] r, input logic fs);
    int unsigned gap;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_blue_in     <= b;
    in_green_in    <= g;
    in_red_in      <= r;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(b, g, r, fs);
    items_sent++;
  endtask

  // Drop valid, drain every owed result, then let the block settle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; call only while the block is drained.
  task automatic write_reg(input logic [bnd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bnd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bnd_pkg::REG_PATTERN)
      cfg_pattern = data[0];
    else if (idx == bnd_pkg::REG_ROW_WIDTH)
      cfg_row_width = data[bnd_pkg::ROW_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send a frame of random pixels; a noisy frame may restart mid-row or stop early.
  task automatic send_frame(input int unsigned rows, input bit noisy);
    int unsigned total, k;
    total = rows * row_limit();
    if (noisy) total = $urandom_range(1, total);
    for (k = 0; k < total; k++)
      send_pixel(rand_byte(), rand_byte(), rand_byte(),
                 k == 0 || (noisy && $urandom_range(31) == 0));
  endtask

  // Start a frame and send only the head of its first row.
  task automatic send_partial_row(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++)
      send_pixel(rand_byte(), rand_byte(), rand_byte(), k == 0);
  endtask

  task automatic pick_idling();
    case ($urandom_range(3))
      0: src_idle_pct = 0;
      1: src_idle_pct = 5;
      2: src_idle_pct = 20;
      default: src_idle_pct = 50;
    endcase
    case ($urandom_range(3))
      0: sink_idle_pct = 0;
      1: sink_idle_pct = 5;
      2: sink_idle_pct = 20;
      default: sink_idle_pct = 50;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Registers untouched: the reset row width is long, so the head of a row gives nothing.
  task automatic test_reset_width();
    pick_idling();
    send_partial_row(PARTIAL_LEN);
    wait_for_drain();
  endtask

  // Saturated and zero bytes in both mosaic layouts.
  task automatic test_extreme_pixels();
    logic [3*bnd_pkg::PIX_W-1:0] quad_pix [8] = '{24'hffffff, 24'h000000, 24'h00ff00,
                                                  24'hff00ff, 24'h000000, 24'hffffff,
                                                  24'h010203, 24'h804020};
    int unsigned pat, k;
    src_idle_pct = 20;
    sink_idle_pct = 20;
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd4);
    for (pat = 0; pat < 2; pat++) begin
      write_reg(bnd_pkg::REG_PATTERN, bnd_pkg::CFG_DATA_W'(pat[0]));
      for (k = 0; k < 8; k++)
        send_pixel(quad_pix[k][23:16], quad_pix[k][15:8], quad_pix[k][7:0], k == 0);
      wait_for_drain();
    end
  endtask

  // Width below the minimum, odd widths, the minimum itself; three rows leave an
  // unpaired last row that must give nothing.
  task automatic test_width_limits();
    logic [bnd_pkg::ROW_W-1:0] widths [5] = '{12'd0, 12'd1, 12'd5, 12'd3, 12'd2};
    int unsigned k;
    pick_idling();
    for (k = 0; k < 5; k++) begin
      write_reg(bnd_pkg::REG_ROW_WIDTH, widths[k]);
      send_frame(3, 1'b0);
      wait_for_drain();
    end
  endtask

  // Narrow the row while an even row is half done: the next pixel is dropped
  // and ends the row, then the odd row pairs with what was stored.
  task automatic test_narrow_mid_row();
    int unsigned k;
    pick_idling();
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd8);
    for (k = 0; k < 5; k++)
      send_pixel(rand_byte(), rand_byte(), rand_byte(), k == 0);
    wait_for_drain();
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd4);
    for (k = 0; k < 5; k++)
      send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0);
    wait_for_drain();
  endtask

  // Widest row, then a width beyond the store that saturates to it; the head of
  // either row gives nothing.
  task automatic test_wide_rows();
    write_reg(bnd_pkg::REG_PATTERN, 12'd1);
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd2048);
    pick_idling();
    send_partial_row(PARTIAL_LEN);
    wait_for_drain();
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'hfff);
    pick_idling();
    send_partial_row(PARTIAL_LEN);
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    write_reg(bnd_pkg::REG_PATTERN, 12'd0);
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd8);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 1'b1;
    send_frame(4, 1'b0);
    wait_for_drain();
  endtask

  // Random settings and frames, mostly narrow rows, some broken frames.
  task automatic test_random_frames();
    int unsigned goal, w, frames;
    goal = items_sent + 130;
    while (items_sent < goal) begin
      pick_idling();
      if ($urandom_range(3) != 0)
        write_reg(bnd_pkg::REG_PATTERN, bnd_pkg::CFG_DATA_W'($urandom_range(1)));
      case ($urandom_range(19))
        14, 15:  w = $urandom_range(13, 32);
        16:      w = $urandom_range(1);
        17:      w = $urandom_range(3, 15) | 1;
        18, 19:  w = $urandom_range(33, 48);
        default: w = $urandom_range(2, 12);
      endcase
      write_reg(bnd_pkg::REG_ROW_WIDTH, w[bnd_pkg::ROW_W-1:0]);
      frames = $urandom_range(1, 2);
      repeat (frames) send_frame($urandom_range(1, 4), $urandom_range(4) == 0);
      wait_for_drain();
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_quiet_tail();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_reg(bnd_pkg::REG_PATTERN, 12'd1);
    write_reg(bnd_pkg::REG_ROW_WIDTH, 12'd16);
    send_frame(4, 1'b0);
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_width();
    test_extreme_pixels();
    test_width_limits();
    test_narrow_mid_row();
    test_wide_rows();
    test_backpressure();
    test_random_frames();
    test_quiet_tail();
    wait_for_drain();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
